/* hw/rtl/tahd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the threshold alarm block with hysteresis and hold delay.
// No dependencies; threshold_alarm_hysteresis_delay_top refers to it by scoped names.
package tahd_pkg;

  typedef enum logic [1:0] {
    ST_OFF     = 2'd0,
    ST_PENDING = 2'd1,
    ST_RAISED  = 2'd2,
    ST_ACK     = 2'd3
  } alarm_state_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_RAISED  = 2'd1,
    EV_CLEARED = 2'd2
  } event_t;

  typedef enum logic [1:0] {
    REQ_READING = 2'd0,
    REQ_TICK    = 2'd1,
    REQ_CONNECT = 2'd2,
    REQ_ACK     = 2'd3
  } req_t;

  localparam logic [2:0] COND_BELOW    = 3'd0;
  localparam logic [2:0] COND_ABOVE    = 3'd1;
  localparam logic [2:0] COND_OUTSIDE  = 3'd2;
  localparam logic [2:0] COND_INSIDE   = 3'd3;
  localparam logic [2:0] COND_OVERLOAD = 3'd4;
  localparam logic [2:0] COND_NOREAD   = 3'd5;

  localparam logic [2:0] CFG_ENABLED    = 3'd0;
  localparam logic [2:0] CFG_CONDITION  = 3'd1;
  localparam logic [2:0] CFG_THRESH_A   = 3'd2;
  localparam logic [2:0] CFG_THRESH_B   = 3'd3;
  localparam logic [2:0] CFG_HYSTERESIS = 3'd4;
  localparam logic [2:0] CFG_HOLD_MS    = 3'd5;

  localparam int unsigned TIME_W = 40;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CMP_W  = 34;

endpackage

/* hw/rtl/threshold_alarm_hysteresis_delay_top.sv */
`timescale 1ns / 1ps
// Threshold alarm channel with hysteresis and hold delay: input register, state
// update logic and result register. Depends on tahd_pkg.
//
// Usage: one instance serves one alarm. Items arrive on the in_ channel (reading,
// tick, set connection, acknowledge) with valid/ready; every item gives exactly
// one result item on the out_ channel with the event, the state after the item
// and the reported value. The cfg_ channel writes the six configuration
// registers by index; it is always ready and is meant to be written while the
// block is idle. Indexes past the last register are accepted and ignored.
// An accepted item waits in the input register until the result register is
// free and then its result is registered. Throughput: one item per cycle while
// out_ready holds, set by the single compare and state pass between the registers.
// A result waiting on a stalled receiver does not block the input register, so
// one more item is taken; after that in_ready follows out_ready.
// Reset (rst_n low, synchronous) empties both registers, puts the alarm off,
// forgets the last reading and the link, and zeroes all configuration.
module threshold_alarm_hysteresis_delay_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic signed [31:0] in_value,
  input  logic               in_overload,
  input  logic               in_connect_on,
  input  logic [39:0]        in_now_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_event_res,
  output logic [1:0]         out_alarm_state,
  output logic signed [31:0] out_report_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int unsigned TW = tahd_pkg::TIME_W;
  localparam int unsigned VW = tahd_pkg::VAL_W;
  localparam int unsigned CW = tahd_pkg::CMP_W;

  // Configuration.
  logic                 enabled_r;
  logic [2:0]           condition_r;
  logic signed [VW-1:0] thresh_a_r;
  logic signed [VW-1:0] thresh_b_r;
  logic [30:0]          hyst_r;
  logic [31:0]          hold_r;

  // Channel state.
  tahd_pkg::alarm_state_t st_r, st_nxt;
  logic [TW-1:0]          pend_since_r, pend_since_nxt;
  logic [TW-1:0]          last_time_r, last_time_nxt;
  logic                   last_valid_r, last_valid_nxt;
  logic [TW-1:0]          conn_since_r, conn_since_nxt;
  logic                   link_r, link_nxt;
  logic signed [VW-1:0]   last_value_r, last_value_nxt;

  // Input register.
  logic                 s1_valid_r;
  tahd_pkg::req_t       s1_req_r;
  logic signed [VW-1:0] s1_value_r;
  logic                 s1_overload_r;
  logic                 s1_connect_r;
  logic [TW-1:0]        s1_now_r;

  // Result register.
  logic                   out_valid_r;
  tahd_pkg::event_t       ev_r, ev_nxt;
  tahd_pkg::alarm_state_t res_st_r;
  logic signed [VW-1:0]   rep_r, rep_nxt;

  logic advance;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign out_valid        = out_valid_r;
  assign out_event_res    = ev_r;
  assign out_alarm_state  = res_st_r;
  assign out_report_value = rep_r;

  // Comparison operands, all at 34 bits so threshold plus or minus band never wraps.
  logic signed [CW-1:0] v34, ta34, tb34, h34, lo34, hi34;
  logic                 match, released;
  logic [TW-1:0]        tick_since;
  logic                 pend_elapsed, tick_elapsed;

  assign v34  = CW'(s1_value_r);
  assign ta34 = CW'(thresh_a_r);
  assign tb34 = CW'(thresh_b_r);
  assign h34  = $signed({{(CW-31){1'b0}}, hyst_r});
  assign lo34 = (ta34 < tb34) ? ta34 : tb34;
  assign hi34 = (ta34 < tb34) ? tb34 : ta34;

  always_comb begin
    match    = 1'b0;
    released = 1'b1;
    if (condition_r == tahd_pkg::COND_OVERLOAD) begin
      match    = s1_overload_r;
      released = !s1_overload_r;
    end else if (condition_r == tahd_pkg::COND_NOREAD) begin
      match    = 1'b0;
      released = 1'b1;
    end else if (s1_overload_r) begin
      // An overloaded reading neither trips nor releases a threshold alarm.
      match    = 1'b0;
      released = 1'b0;
    end else begin
      case (condition_r)
        tahd_pkg::COND_BELOW: begin
          match    = v34 < ta34;
          released = v34 >= ta34 + h34;
        end
        tahd_pkg::COND_ABOVE: begin
          match    = v34 > ta34;
          released = v34 <= ta34 - h34;
        end
        tahd_pkg::COND_OUTSIDE: begin
          match    = (v34 < lo34) || (v34 > hi34);
          released = (v34 >= lo34 + h34) && (v34 <= hi34 - h34);
        end
        tahd_pkg::COND_INSIDE: begin
          match    = (v34 >= lo34) && (v34 <= hi34);
          released = (v34 < lo34 - h34) || (v34 > hi34 + h34);
        end
        default: begin
          match    = 1'b0;
          released = 1'b1;
        end
      endcase
    end
  end

  // A clock that runs backwards counts as not yet elapsed.
  function automatic logic time_elapsed(input logic [TW-1:0] now, input logic [TW-1:0] since,
                                        input logic [31:0] hold);
    logic [TW-1:0] diff;
    diff = now - since;
    return (now >= since) && (diff >= TW'(hold));
  endfunction

  assign tick_since   = last_valid_r ? last_time_r : conn_since_r;
  assign pend_elapsed = time_elapsed(s1_now_r, pend_since_r, hold_r);
  assign tick_elapsed = time_elapsed(s1_now_r, tick_since, hold_r);

  always_comb begin
    st_nxt         = st_r;
    pend_since_nxt = pend_since_r;
    last_time_nxt  = last_time_r;
    last_valid_nxt = last_valid_r;
    conn_since_nxt = conn_since_r;
    link_nxt       = link_r;
    last_value_nxt = last_value_r;
    ev_nxt         = tahd_pkg::EV_NONE;
    rep_nxt        = '0;
    case (s1_req_r)
      tahd_pkg::REQ_READING: begin
        last_time_nxt  = s1_now_r;
        last_valid_nxt = 1'b1;
        last_value_nxt = s1_value_r;
        if (condition_r == tahd_pkg::COND_NOREAD || !enabled_r) begin
          if (st_r != tahd_pkg::ST_OFF) begin
            st_nxt = tahd_pkg::ST_OFF;
            ev_nxt = tahd_pkg::EV_CLEARED;
          end
          if (condition_r == tahd_pkg::COND_NOREAD) begin
            pend_since_nxt = s1_now_r;
          end
        end else begin
          case (st_r)
            tahd_pkg::ST_OFF: begin
              if (match) begin
                pend_since_nxt = s1_now_r;
                if (hold_r == '0) begin
                  st_nxt  = tahd_pkg::ST_RAISED;
                  ev_nxt  = tahd_pkg::EV_RAISED;
                  rep_nxt = s1_value_r;
                end else begin
                  st_nxt = tahd_pkg::ST_PENDING;
                end
              end
            end
            tahd_pkg::ST_PENDING: begin
              if (!match) begin
                st_nxt = tahd_pkg::ST_OFF;
              end else if (pend_elapsed) begin
                st_nxt  = tahd_pkg::ST_RAISED;
                ev_nxt  = tahd_pkg::EV_RAISED;
                rep_nxt = s1_value_r;
              end
            end
            default: begin
              if (released) begin
                st_nxt = tahd_pkg::ST_OFF;
                ev_nxt = tahd_pkg::EV_CLEARED;
              end
            end
          endcase
        end
      end
      tahd_pkg::REQ_TICK: begin
        if (condition_r == tahd_pkg::COND_NOREAD && enabled_r && (last_valid_r || link_r) &&
            tick_elapsed && st_r == tahd_pkg::ST_OFF) begin
          st_nxt  = tahd_pkg::ST_RAISED;
          ev_nxt  = tahd_pkg::EV_RAISED;
          rep_nxt = last_value_r;
        end
      end
      tahd_pkg::REQ_CONNECT: begin
        if (s1_connect_r != link_r) begin
          link_nxt       = s1_connect_r;
          conn_since_nxt = s1_connect_r ? s1_now_r : '0;
          last_valid_nxt = 1'b0;
          if (!s1_connect_r && condition_r == tahd_pkg::COND_NOREAD &&
              st_r != tahd_pkg::ST_OFF) begin
            st_nxt = tahd_pkg::ST_OFF;
            if (st_r != tahd_pkg::ST_PENDING) begin
              ev_nxt = tahd_pkg::EV_CLEARED;
            end
          end
        end
      end
      default: begin
        if (st_r == tahd_pkg::ST_RAISED) begin
          st_nxt = tahd_pkg::ST_ACK;
        end
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b0;
      condition_r <= '0;
      thresh_a_r  <= '0;
      thresh_b_r  <= '0;
      hyst_r      <= '0;
      hold_r      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tahd_pkg::CFG_ENABLED:    enabled_r   <= cfg_data[0];
        tahd_pkg::CFG_CONDITION:  condition_r <= cfg_data[2:0];
        tahd_pkg::CFG_THRESH_A:   thresh_a_r  <= $signed(cfg_data);
        tahd_pkg::CFG_THRESH_B:   thresh_b_r  <= $signed(cfg_data);
        tahd_pkg::CFG_HYSTERESIS: hyst_r      <= cfg_data[30:0];
        tahd_pkg::CFG_HOLD_MS:    hold_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake control and channel state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      st_r         <= tahd_pkg::ST_OFF;
      pend_since_r <= '0;
      last_time_r  <= '0;
      last_valid_r <= 1'b0;
      conn_since_r <= '0;
      link_r       <= 1'b0;
      last_value_r <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (advance && s1_valid_r) begin
        st_r         <= st_nxt;
        pend_since_r <= pend_since_nxt;
        last_time_r  <= last_time_nxt;
        last_valid_r <= last_valid_nxt;
        conn_since_r <= conn_since_nxt;
        link_r       <= link_nxt;
        last_value_r <= last_value_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_r      <= tahd_pkg::req_t'(in_req_type);
      s1_value_r    <= in_value;
      s1_overload_r <= in_overload;
      s1_connect_r  <= in_connect_on;
      s1_now_r      <= in_now_ms;
    end
    if (advance && s1_valid_r) begin
      ev_r     <= ev_nxt;
      res_st_r <= st_nxt;
      rep_r    <= rep_nxt;
    end
  end

endmodule
